FILE: rtl/afrc_pkg.sv
`timescale 1ns / 1ps

package afrc_pkg;

   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ENQ = 8'h05;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_ETB = 8'h17;

   localparam logic [2:0] ST_ENQ   = 3'd0;
   localparam logic [2:0] ST_ACK   = 3'd1;
   localparam logic [2:0] ST_NAK   = 3'd2;
   localparam logic [2:0] ST_EOT   = 3'd3;
   localparam logic [2:0] ST_GOOD  = 3'd4;
   localparam logic [2:0] ST_CKERR = 3'd5;
   localparam logic [2:0] ST_FMT   = 3'd6;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] frame_sum;
   } rsp_payload_type;

   // per-byte outcome from the frame tracker
   typedef struct packed {
      logic            emit;
      rsp_payload_type payload;
   } step_result_type;

   // one nibble as an upper-case ASCII hex digit
   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h41 + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

FILE: rtl/afrc_stream_if.sv
`timescale 1ns / 1ps

interface afrc_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/afrc_frame_tracker.sv
`timescale 1ns / 1ps

module afrc_frame_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_byte,
   output afrc_pkg::step_result_type result
);
   import afrc_pkg::*;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_BODY    = 3'd1;
   localparam logic [2:0] PH_CHECK   = 3'd2;
   localparam logic [2:0] PH_WAIT_LF = 3'd3;
   localparam logic [2:0] PH_SKIP    = 3'd4;
   localparam logic [2:0] PH_SKIP_LF = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] high_ff, high_in;
   logic [7:0] low_ff, low_in;
   logic       high_done_ff, high_done_in;
   logic       is_end;
   logic       sum_ok;

   assign is_end = (rx_byte == CH_ETX) || (rx_byte == CH_ETB);
   assign sum_ok = (high_ff == hex_upper(sum_ff[7:4])) && (low_ff == hex_upper(sum_ff[3:0]));

   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      high_done_in = high_done_ff;
      result       = '0;
      case (phase_ff)
         PH_BODY: begin
            sum_in = sum_ff + rx_byte;
            if (is_end) begin
               high_done_in = 1'b0;
               phase_in     = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (!high_done_ff) begin
               high_in      = rx_byte;
               high_done_in = 1'b1;
            end else begin
               low_in   = rx_byte;
               phase_in = PH_WAIT_LF;
            end
         end
         PH_WAIT_LF: begin
            if (rx_byte == CH_LF) begin
               phase_in                 = PH_IDLE;
               result.emit              = 1'b1;
               result.payload.status    = sum_ok ? ST_GOOD : ST_CKERR;
               result.payload.frame_sum = sum_ff;
            end
         end
         PH_SKIP: begin
            if (is_end) begin
               phase_in = PH_SKIP_LF;
            end
         end
         PH_SKIP_LF: begin
            if (rx_byte == CH_LF) begin
               phase_in              = PH_IDLE;
               result.emit           = 1'b1;
               result.payload.status = ST_FMT;
            end
         end
         default: begin
            // idle, and unused codes: first byte of a packet
            phase_in = PH_SKIP;
            case (rx_byte)
               CH_ENQ: begin
                  phase_in              = PH_IDLE;
                  result.emit           = 1'b1;
                  result.payload.status = ST_ENQ;
               end
               CH_ACK: begin
                  phase_in              = PH_IDLE;
                  result.emit           = 1'b1;
                  result.payload.status = ST_ACK;
               end
               CH_NAK: begin
                  phase_in              = PH_IDLE;
                  result.emit           = 1'b1;
                  result.payload.status = ST_NAK;
               end
               CH_EOT: begin
                  phase_in              = PH_IDLE;
                  result.emit           = 1'b1;
                  result.payload.status = ST_EOT;
               end
               CH_STX: begin
                  phase_in     = PH_BODY;
                  sum_in       = '0;
                  high_in      = '0;
                  low_in       = '0;
                  high_done_in = 1'b0;
               end
               default: begin
                  phase_in = PH_SKIP;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sum_ff       <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         high_done_ff <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         high_done_ff <= high_done_in;
      end
   end

endmodule

FILE: rtl/astm_frame_receive_checker.sv
`timescale 1ns / 1ps

// Checks received ASTM low-level link bytes, one item per byte. ENQ, ACK, NAK
// or EOT as the first byte of a packet gives a control status at once; an STX
// frame is summed modulo 256 through ETX/ETB, the next two bytes are compared
// with the sum as upper-case hex, and the following LF reports frame good or
// checksum error with the sum. Any other first byte is skipped to ETX/ETB and
// LF and reported as a format error. A byte is taken into an input register,
// processed by the frame tracker, and its status, if any, is registered in an
// output register; one byte per cycle is sustained while statuses are taken.
// While the receiver holds off a status, the next byte waits in the input
// register and the input stalls.
module astm_frame_receive_checker (
   input  logic          clock,
   input  logic          reset,
   afrc_stream_if.sink   req_if,
   afrc_stream_if.source rsp_if
);
   import afrc_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     out_data_ff;
   logic                fire;
   step_result_type     result;

   assign fire          = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || fire;
   assign in_valid_in   = req_if.valid || (in_valid_ff && !fire);
   assign out_valid_in  = (fire && result.emit) || (out_valid_ff && !rsp_if.ready);

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_data_ff;

   afrc_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         in_byte_ff <= req_if.payload.rx_byte;
      end
      if (fire && result.emit) begin
         out_data_ff <= result.payload;
      end
   end

endmodule

FILE: rtl/afrc_checker.sv
`timescale 1ns / 1ps

module afrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_frame_sum
);
   import afrc_pkg::*;

   // a waiting status holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_frame_sum))
      else $error("status dropped or changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FMT)
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_GOOD && rsp_status != ST_CKERR |-> rsp_frame_sum == 8'd0)
      else $error("nonzero sum on control or format status");

   // a fresh status needs an earlier accepted byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("status without a preceding item");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("status valid right after reset");

endmodule

bind astm_frame_receive_checker afrc_checker u_afrc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.payload.status),
   .rsp_frame_sum (rsp_if.payload.frame_sum)
);
